// File: rtl/p2gka_pkg.sv
`default_nettype none
package p2gka_pkg;

   // configuration register indexes
   localparam logic CSR_INV_VOXEL_SIZE = 1'b0;
   localparam logic CSR_KERNEL_MODE    = 1'b1;
   localparam int   CSR_INDEX_W        = 1;

   // fixed field widths
   localparam int POS_W  = 32;
   localparam int DIFF_W = POS_W + 1;      // magnitude of a coordinate difference
   localparam int DENS_W = 16;
   localparam int SQ_W   = 2 * DIFF_W;     // sum of three squares
   localparam int VSUM_W = 48;
   localparam int WSUM_W = 32;

   // one classified particle word between front and back
   typedef struct packed {
      logic [DIFF_W-1:0] ax;
      logic [DIFF_W-1:0] ay;
      logic [DIFF_W-1:0] az;
      logic [DENS_W-1:0] dens;
      logic              empty;
      logic              last;
   } item_type;

   typedef struct packed {
      logic [31:0] inv_voxel_size;
      logic        kernel_mode;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_SQRT, ST_MULA, ST_MULB, ST_RCAP, ST_K1, ST_K2, ST_K3,
      ST_WMUL, ST_ACC, ST_FIN, ST_DIV, ST_OUT
   } state_type;

endpackage
`default_nettype wire

// File: rtl/p2gka_front.sv
`default_nettype none
module p2gka_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [31:0]            req_voxel_x,
   input  wire logic signed [31:0]            req_voxel_y,
   input  wire logic signed [31:0]            req_voxel_z,
   input  wire logic signed [31:0]            req_part_x,
   input  wire logic signed [31:0]            req_part_y,
   input  wire logic signed [31:0]            req_part_z,
   input  wire logic [15:0]                   req_part_density,
   input  wire logic                          req_empty_voxel,
   input  wire logic                          req_last_particle,
   output p2gka_pkg::item_type                pop_item,
   output logic                               pop_valid,
   input  wire logic                          pop_ready
);
   import p2gka_pkg::*;

   item_type   fifo_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   cls;
   logic       push, pop;

   function automatic logic [DIFF_W-1:0] absdiff(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [DIFF_W-1:0] d;
      d = {a[31], a} - {b[31], b};
      return d[DIFF_W-1] ? -d : d;
   endfunction

   // classify: coordinate distance magnitudes and voxel flags
   always_comb begin
      cls.ax    = absdiff(req_voxel_x, req_part_x);
      cls.ay    = absdiff(req_voxel_y, req_part_y);
      cls.az    = absdiff(req_voxel_z, req_part_z);
      cls.dens  = req_part_density;
      cls.empty = req_empty_voxel;
      cls.last  = req_last_particle;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_item  = fifo_ff[rd_ptr_ff];

   // two-word queue
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

// File: rtl/p2gka_back.sv
`default_nettype none
module p2gka_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire p2gka_pkg::cfg_type   cfg,
   input  wire p2gka_pkg::item_type  pop_item,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [15:0]               rsp_voxel_density,
   output logic                      rsp_saturated
);
   import p2gka_pkg::*;

   localparam int RW = FRAC_BITS + 2;            // r capped at 3.0
   localparam int WW = FRAC_BITS + 4;            // signed weight
   localparam int TW = WW + DENS_W + 1;          // weight times density
   localparam logic [RW-1:0] ONE   = RW'(1) << FRAC_BITS;
   localparam logic [RW-1:0] TWO   = RW'(2) << FRAC_BITS;
   localparam logic [RW-1:0] THREE = RW'(3) << FRAC_BITS;

   state_type              state_ff, state_in;
   item_type               item_ff, item_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [SQ_W-1:0]        sum_ff, sum_in;
   logic [35:0]            rem_ff, rem_in;
   logic [DIFF_W-1:0]      res_ff, res_in;
   logic [48:0]            pa_ff, pa_in;
   logic [48:0]            lil_ff, lil_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [2*RW-1:0]        mul_ff, mul_in;
   logic [RW-1:0]          sq_ff, sq_in;
   logic signed [WW-1:0]   w_ff, w_in;
   logic signed [TW-1:0]   term_ff, term_in;
   logic signed [VSUM_W-1:0] vsum_ff, vsum_in;
   logic signed [WSUM_W-1:0] wsum_ff, wsum_in;
   logic                   ovf_ff, ovf_in;
   logic [VSUM_W-1:0]      dq_ff, dq_in;
   logic [WSUM_W:0]        dvs_ff, dvs_in;
   logic [WSUM_W:0]        drem_ff, drem_in;
   logic                   zero_ff, zero_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_dens_ff, rsp_dens_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   // scratch
   logic [DIFF_W-1:0]      sel;
   logic [35:0]            rem_sh, trial;
   logic [63:0]            scaled;
   logic [63:0]            rq;
   logic signed [WW-1:0]   t5, t3;
   logic signed [VSUM_W:0] vs;
   logic signed [WSUM_W:0] ws;
   logic [WSUM_W:0]        drem_sh;
   logic [VSUM_W-1:0]      vmag;
   logic [WSUM_W-1:0]      wmag;

   assign pop_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voxel_density = rsp_dens_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;  item_in = item_ff;  cnt_in = cnt_ff;
      sum_in = sum_ff;  rem_in = rem_ff;  res_in = res_ff;
      pa_in = pa_ff;  lil_in = lil_ff;  r_in = r_ff;  mul_in = mul_ff;
      sq_in = sq_ff;  w_in = w_ff;  term_in = term_ff;
      vsum_in = vsum_ff;  wsum_in = wsum_ff;  ovf_in = ovf_ff;
      dq_in = dq_ff;  dvs_in = dvs_ff;  drem_in = drem_ff;  zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dens_in = rsp_dens_ff;  rsp_sat_in = rsp_sat_ff;
      sel = item_ff.ax;  rem_sh = '0;  trial = '0;  scaled = '0;  rq = '0;
      t5 = '0;  t3 = '0;  vs = '0;  ws = '0;  drem_sh = '0;  vmag = '0;  wmag = '0;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               item_in  = pop_item;
               sum_in   = '0;
               cnt_in   = '0;
               state_in = pop_item.empty ? ST_FIN : ST_SQ;
            end
         end
         // one square per cycle
         ST_SQ: begin
            sel = (cnt_ff == 6'd0) ? item_ff.ax : (cnt_ff == 6'd1) ? item_ff.ay : item_ff.az;
            sum_in = sum_ff + (SQ_W'(sel) * SQ_W'(sel));
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               cnt_in   = '0;
               rem_in   = '0;
               res_in   = '0;
               state_in = ST_SQRT;
            end
         end
         // one root bit per cycle
         ST_SQRT: begin
            rem_sh = {rem_ff[33:0], sum_ff[SQ_W-1 -: 2]};
            trial  = {1'b0, res_ff, 2'b01};
            sum_in = sum_ff << 2;
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               res_in = {res_ff[DIFF_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               res_in = {res_ff[DIFF_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIFF_W - 1)) state_in = ST_MULA;
         end
         ST_MULA: begin
            pa_in    = 49'(res_ff) * 49'(cfg.inv_voxel_size[31:16]);
            state_in = ST_MULB;
         end
         ST_MULB: begin
            lil_in   = 49'(res_ff) * 49'(cfg.inv_voxel_size[15:0]);
            state_in = ST_RCAP;
         end
         ST_RCAP: begin
            scaled = ({15'd0, pa_ff} << 16) + {15'd0, lil_ff};
            rq     = scaled >> FRAC_BITS;
            if (pa_ff[48:47] != 2'b00 || rq > 64'(THREE)) r_in = THREE;
            else r_in = rq[RW-1:0];
            state_in = ST_K1;
         end
         ST_K1: begin
            if (!cfg.kernel_mode) begin
               w_in     = (r_ff > ONE) ? '0 : WW'(ONE - r_ff);
               state_in = ST_WMUL;
            end else if (r_ff > TWO) begin
               w_in     = '0;
               state_in = ST_WMUL;
            end else begin
               if (r_ff >= ONE) mul_in = (2*RW)'(TWO - r_ff) * (2*RW)'(TWO - r_ff);
               else             mul_in = (2*RW)'(r_ff) * (2*RW)'(r_ff);
               state_in = ST_K2;
            end
         end
         ST_K2: begin
            sq_in = RW'(mul_ff >> FRAC_BITS);
            if (r_ff >= ONE) mul_in = (2*RW)'(sq_in) * (2*RW)'(r_ff - ONE);
            else             mul_in = (2*RW)'(sq_in) * (2*RW)'(r_ff);
            state_in = ST_K3;
         end
         ST_K3: begin
            if (r_ff >= ONE) begin
               w_in = -WW'(mul_ff >> (FRAC_BITS + 1));
            end else begin
               t5   = WW'((WW'(sq_ff) * WW'(5)) >> 1);
               t3   = WW'((WW'(mul_ff >> FRAC_BITS) * WW'(3)) >> 1);
               w_in = WW'(ONE) - t5 + t3;
            end
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            term_in  = TW'(w_ff) * $signed({{(TW-DENS_W){1'b0}}, item_ff.dens});
            state_in = ST_ACC;
         end
         // saturating sums
         ST_ACC: begin
            vs = (VSUM_W+1)'(vsum_ff) + (VSUM_W+1)'(term_ff);
            ws = (WSUM_W+1)'(wsum_ff) + (WSUM_W+1)'(w_ff);
            if (vs[VSUM_W] != vs[VSUM_W-1]) begin
               ovf_in  = 1'b1;
               vsum_in = vs[VSUM_W] ? {1'b1, {(VSUM_W-1){1'b0}}} : {1'b0, {(VSUM_W-1){1'b1}}};
            end else begin
               vsum_in = vs[VSUM_W-1:0];
            end
            if (ws[WSUM_W] != ws[WSUM_W-1]) begin
               ovf_in  = 1'b1;
               wsum_in = ws[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
            end else begin
               wsum_in = ws[WSUM_W-1:0];
            end
            state_in = item_ff.last ? ST_FIN : ST_IDLE;
         end
         // set up magnitude division; mixed signs or a zero weight sum clamp to zero
         ST_FIN: begin
            vmag    = vsum_ff[VSUM_W-1] ? -vsum_ff : vsum_ff;
            wmag    = wsum_ff[WSUM_W-1] ? -wsum_ff : wsum_ff;
            zero_in = (wsum_ff == '0) || (vsum_ff[VSUM_W-1] != wsum_ff[WSUM_W-1]);
            dq_in   = vmag;
            dvs_in  = {1'b0, wmag};
            drem_in = '0;
            cnt_in  = '0;
            state_in = zero_in ? ST_OUT : ST_DIV;
         end
         // one quotient bit per cycle
         ST_DIV: begin
            drem_sh = {drem_ff[WSUM_W-1:0], dq_ff[VSUM_W-1]};
            if (drem_sh >= dvs_ff) begin
               drem_in = drem_sh - dvs_ff;
               dq_in   = {dq_ff[VSUM_W-2:0], 1'b1};
            end else begin
               drem_in = drem_sh;
               dq_in   = {dq_ff[VSUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(VSUM_W - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = ovf_ff;
               if (zero_ff)                      rsp_dens_in = '0;
               else if (dq_ff[VSUM_W-1:16] != '0) rsp_dens_in = 16'hFFFF;
               else                              rsp_dens_in = dq_ff[15:0];
               vsum_in  = '0;
               wsum_in  = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;  cnt_ff <= cnt_in;  sum_ff <= sum_in;
      rem_ff <= rem_in;  res_ff <= res_in;  pa_ff <= pa_in;  lil_ff <= lil_in;
      r_ff <= r_in;  mul_ff <= mul_in;  sq_ff <= sq_in;  w_ff <= w_in;
      term_ff <= term_in;  dq_ff <= dq_in;  dvs_ff <= dvs_in;  drem_ff <= drem_in;
      zero_ff <= zero_in;  rsp_dens_ff <= rsp_dens_in;  rsp_sat_ff <= rsp_sat_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         vsum_ff      <= '0;
         wsum_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vsum_ff      <= vsum_in;
         wsum_ff      <= wsum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new result word only comes out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

   // sums are cleared whenever a result word is loaded
   a_clear_on_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) |=>
      (vsum_ff == '0 && wsum_ff == '0 && !ovf_ff))
      else $error("sums not cleared after result");

   // divider step count stays within the dividend width
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < 6'(VSUM_W)))
      else $error("divider ran past its width");

endmodule
`default_nettype wire

// File: rtl/particle_to_grid_kernel_average_core.sv
// Flow: a word passes the queue, 3 square steps, 33 root steps, scale, kernel, weight and
//   accumulate before it updates the sums. A closing word then adds setup, 48 quotient steps
//   and output load before its result is valid; an empty word goes straight to setup and a zero
//   result skips the quotient steps. Words are taken only when idle; root and divider set the pace.
// Reset: synchronous, active high; clears queue, sums, sequencer and output valid,
//   sets inv_voxel_size to 1.0 and kernel_mode to linear.
`default_nettype none
module particle_to_grid_kernel_average_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_voxel_x,
   input  wire logic signed [31:0]    req_voxel_y,
   input  wire logic signed [31:0]    req_voxel_z,
   input  wire logic signed [31:0]    req_part_x,
   input  wire logic signed [31:0]    req_part_y,
   input  wire logic signed [31:0]    req_part_z,
   input  wire logic [15:0]           req_part_density,
   input  wire logic                  req_empty_voxel,
   input  wire logic                  req_last_particle,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [15:0]                rsp_voxel_density,
   output logic                       rsp_saturated,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [p2gka_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]           csr_wdata
);
   import p2gka_pkg::*;

   cfg_type  cfg_ff;
   item_type pop_item;
   logic     pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_voxel_size <= 32'd65536;
         cfg_ff.kernel_mode    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INV_VOXEL_SIZE: cfg_ff.inv_voxel_size <= csr_wdata;
            CSR_KERNEL_MODE:    cfg_ff.kernel_mode    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   p2gka_front u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_voxel_x, .req_voxel_y, .req_voxel_z,
      .req_part_x, .req_part_y, .req_part_z,
      .req_part_density, .req_empty_voxel, .req_last_particle,
      .pop_item, .pop_valid, .pop_ready
   );

   p2gka_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .pop_item, .pop_valid, .pop_ready,
      .rsp_valid, .rsp_stall, .rsp_voxel_density, .rsp_saturated
   );

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import p2gka_pkg::*;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_M4     = 1'b1;
   localparam int   WATCHDOG    = 20000;
   localparam int   HOLD_CYCLES = 1500;
   localparam int   PHASE_ITEMS = 225;
   localparam int   NUM_PHASES  = 8;

   typedef struct {
      logic signed [31:0] vx, vy, vz, px, py, pz;
      logic [15:0]        dens;
      logic               empty;
      logic               last;
   } particle_type;

   typedef struct {
      logic [15:0] density;
      logic        sat;
   } voxel_result_type;

   typedef struct {
      particle_type p;
      logic         typed;
      logic [15:0]  density;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [31:0] req_voxel_x, req_voxel_y, req_voxel_z;
   logic signed [31:0] req_part_x, req_part_y, req_part_z;
   logic [15:0] req_part_density;
   logic req_empty_voxel, req_last_particle;
   logic rsp_valid, rsp_stall;
   logic [15:0] rsp_voxel_density;
   logic rsp_saturated;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   particle_to_grid_kernel_average_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_voxel_x(req_voxel_x), .req_voxel_y(req_voxel_y), .req_voxel_z(req_voxel_z),
      .req_part_x(req_part_x), .req_part_y(req_part_y), .req_part_z(req_part_z),
      .req_part_density(req_part_density),
      .req_empty_voxel(req_empty_voxel), .req_last_particle(req_last_particle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_voxel_density(rsp_voxel_density), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the block's configuration and sums
   logic [31:0] cur_inv;
   logic        cur_mode;
   longint      vsum, wsum;
   logic        ovf;

   voxel_result_type density_q[$];
   int  mismatches;
   int  idle_cycles;
   int  sent_words;
   logic quiet;
   logic hold_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // exact floor square root of a 68-bit value
   function automatic logic [63:0] root68(input logic [67:0] v);
      logic [71:0] res, rem, trial;
      res = '0;
      rem = '0;
      for (int i = 33; i >= 0; i--) begin
         rem   = (rem << 2) | v[2*i +: 2];
         trial = (res << 2) | 72'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            res = (res << 1) | 72'd1;
         end else begin
            res = res << 1;
         end
      end
      return res[63:0];
   endfunction

   function automatic longint kernel_w(input logic [63:0] r, input logic mode);
      logic [63:0] one, t, t2, r2, r3;
      one = 64'd1 << 16;
      if (mode == MODE_LINEAR) begin
         if (r > one) return 0;
         return longint'(one - r);
      end
      if (r > 2 * one) return 0;
      if (r >= one) begin
         t  = 2 * one - r;
         t2 = (t * t) >> 16;
         return -longint'((t2 * (r - one)) >> 17);
      end
      r2 = (r * r) >> 16;
      r3 = (r2 * r) >> 16;
      return longint'(one) - longint'((5 * r2) >> 1) + longint'((3 * r3) >> 1);
   endfunction

   function automatic longint sat_add(input longint acc, input longint term,
                                      input longint lo, input longint hi);
      longint s;
      s = acc + term;
      if (s > hi) begin ovf = 1'b1; return hi; end
      if (s < lo) begin ovf = 1'b1; return lo; end
      return s;
   endfunction

   function automatic logic [67:0] absd(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return 68'(d);
   endfunction

   // advance the shadow sums; returns 1 when the word closes a voxel
   function automatic logic accumulate_voxel(input particle_type p,
                                             output voxel_result_type res);
      logic [67:0] ax, ay, az, sq;
      logic [63:0] len, ih, il, pa, r;
      longint w, d;
      if (!p.empty) begin
         ax  = absd(p.vx, p.px);
         ay  = absd(p.vy, p.py);
         az  = absd(p.vz, p.pz);
         sq  = ax * ax + ay * ay + az * az;
         len = root68(sq);
         ih  = 64'(cur_inv >> 16);
         il  = 64'(cur_inv & 32'hFFFF);
         pa  = len * ih;
         if (pa >= (64'd1 << 47)) begin
            r = 64'd3 << 16;
         end else begin
            r = ((pa << 16) + len * il) >> 16;
            if (r > (64'd3 << 16)) r = 64'd3 << 16;
         end
         w    = kernel_w(r, cur_mode);
         vsum = sat_add(vsum, w * longint'({48'd0, p.dens}),
                        -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
         wsum = sat_add(wsum, w, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      end
      res.density = '0;
      res.sat     = 1'b0;
      if (!p.empty && !p.last) return 1'b0;
      d = (wsum == 0) ? 0 : vsum / wsum;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      res.density = d[15:0];
      res.sat     = ovf;
      vsum = 0;
      wsum = 0;
      ovf  = 1'b0;
      return 1'b1;
   endfunction

   // drive one particle word, wait for it to be taken, record its result
   task automatic send_word(input particle_type p, input logic typed, input logic [15:0] tden);
      voxel_result_type res;
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         n = $urandom_range(1, 10);
         repeat (n) @(negedge clock);
      end
      req_voxel_x = p.vx; req_voxel_y = p.vy; req_voxel_z = p.vz;
      req_part_x = p.px; req_part_y = p.py; req_part_z = p.pz;
      req_part_density = p.dens;
      req_empty_voxel = p.empty;
      req_last_particle = p.last;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_words++;
      if (accumulate_voxel(p, res)) begin
         if (typed) begin
            res.density = tden;
            res.sat     = 1'b0;
         end
         density_q.push_back(res);
      end
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      req_valid = 1'b0;
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_INV_VOXEL_SIZE) cur_inv = data;
      else cur_mode = data[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // let the block finish everything in flight
   task automatic drain();
      req_valid = 1'b0;
      while (density_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic particle_type mk(input logic [31:0] vx, vy, vz, px, py, pz,
                                       input logic [15:0] dens, input logic empty, last);
      particle_type p;
      p.vx = vx; p.vy = vy; p.vz = vz;
      p.px = px; p.py = py; p.pz = pz;
      p.dens = dens; p.empty = empty; p.last = last;
      return p;
   endfunction

   function automatic logic [31:0] near(input logic [31:0] v, input longint span);
      longint off;
      off = longint'($urandom_range(0, 32'(2 * span))) - span;
      return v + off[31:0];
   endfunction

   // one voxel of random content: mostly well formed, some noise
   task automatic send_voxel(input longint span);
      particle_type p;
      logic [31:0] vx, vy, vz;
      int n, kind;
      kind = $urandom_range(0, 99);
      vx = $urandom; vy = $urandom; vz = $urandom;
      if (kind < 6) begin
         p = mk(vx, vy, vz, $urandom, $urandom, $urandom, 16'($urandom), 1'b1,
                1'($urandom_range(0, 1)));
         send_word(p, 1'b0, '0);
         return;
      end
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            p = mk(vx, vy, vz, $urandom, $urandom, $urandom, 16'($urandom), 1'b0, k == n - 1);
         else
            p = mk(vx, vy, vz, near(vx, span), near(vy, span), near(vz, span),
                   16'($urandom), 1'b0, k == n - 1);
         // broken voxel: closed early by an empty word
         if (kind < 10 && k == n - 1) p.empty = 1'b1;
         send_word(p, 1'b0, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      voxel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (density_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result density=%h sat=%b", rsp_voxel_density, rsp_saturated);
         end else begin
            want = density_q.pop_front();
            if (want.density !== rsp_voxel_density || want.sat !== rsp_saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected density=%h sat=%b, got density=%h sat=%b",
                           want.density, want.sat, rsp_voxel_density, rsp_saturated);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall bursts and the long hold-off
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_req  = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            n = $urandom_range(1, 10);
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   logic [31:0]  phase_inv[NUM_PHASES];
   logic         phase_mode[NUM_PHASES];
   stim_row_type rows[$];

   initial begin
      longint span;
      stim_row_type r;
      int start;
      logic held;
      reset = 1'b1;
      req_valid = 1'b0;
      req_voxel_x = '0; req_voxel_y = '0; req_voxel_z = '0;
      req_part_x = '0; req_part_y = '0; req_part_z = '0;
      req_part_density = '0; req_empty_voxel = 1'b0; req_last_particle = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      quiet = 1'b0; hold_req = 1'b0; held = 1'b0;
      mismatches = 0; idle_cycles = 0; sent_words = 0;
      cur_inv = 32'd65536; cur_mode = MODE_LINEAR;
      vsum = 0; wsum = 0; ovf = 1'b0;

      // directed words under reset settings
      r.typed = 1'b1;
      r.density = 16'h0000; r.p = mk(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0); rows.push_back(r);
      r.density = 16'hFFFF; r.p = mk(5, 6, 7, 5, 6, 7, 16'hFFFF, 1'b0, 1'b1); rows.push_back(r);
      r.density = 16'h0000;
      r.p = mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 16'hFFFF, 1'b0, 1'b1); rows.push_back(r);
      r.p = mk(1, 2, 3, 1, 2, 3, 16'h0100, 1'b0, 1'b0); rows.push_back(r);
      // empty word closes the open voxel with the sums held so far
      r.density = 16'h0100;
      r.p = mk(32'hFFFFFFFF, 0, 32'h12345678, 32'hDEADBEEF, 32'hFFFFFFFF, 0, 16'hFFFF,
               1'b1, 1'b0); rows.push_back(r);
      r.density = 16'h0000;
      r.p = mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
               32'h80000000, 16'h0000, 1'b0, 1'b1); rows.push_back(r);
      r.density = 16'h1234; r.p = mk(0, 0, 0, 32'h8000, 0, 0, 16'h1234, 1'b0, 1'b1);
      rows.push_back(r);
      r.p = mk(0, 0, 0, 0, 32'h10000, 0, 16'hFFFF, 1'b0, 1'b0); rows.push_back(r);
      r.density = 16'h0200; r.p = mk(9, 9, 9, 9, 9, 9, 16'h0200, 1'b0, 1'b1); rows.push_back(r);
      r.density = 16'h0000; r.p = mk(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1); rows.push_back(r);
      r.typed = 1'b0;
      r.p = mk(0, 0, 0, 32'h3000, 32'h4000, 0, 16'hABCD, 1'b0, 1'b0); rows.push_back(r);
      r.p = mk(0, 0, 0, 0, 0, 32'hFFFF0000, 16'h00FF, 1'b0, 1'b1); rows.push_back(r);

      phase_inv[0] = 32'd65536;    phase_mode[0] = MODE_LINEAR;
      phase_inv[1] = 32'd65536;    phase_mode[1] = MODE_M4;
      phase_inv[2] = 32'd0;        phase_mode[2] = MODE_LINEAR;
      phase_inv[3] = 32'hFFFFFFFF; phase_mode[3] = MODE_M4;
      phase_inv[4] = 32'd1;        phase_mode[4] = MODE_LINEAR;
      phase_inv[5] = $urandom;     phase_mode[5] = MODE_M4;
      phase_inv[6] = 32'd131072;   phase_mode[6] = MODE_LINEAR;
      phase_inv[7] = 32'd32768;    phase_mode[7] = MODE_M4;

      repeat (8) @(posedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (rows[i]) send_word(rows[i].p, rows[i].typed, rows[i].density);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         csr_write(CSR_INV_VOXEL_SIZE, phase_inv[ph]);
         csr_write(CSR_KERNEL_MODE, {31'd0, phase_mode[ph]});
         quiet = (ph == NUM_PHASES - 1);
         // per-axis distance span that reaches r = 3.0, past the kernel radius
         if (cur_inv == 0) span = 64'd1 << 30;
         else span = (longint'(3) << 32) / longint'(cur_inv);
         if (span > (64'd1 << 30)) span = 64'd1 << 30;
         if (span < 4) span = 4;
         start = sent_words;
         while (sent_words - start < PHASE_ITEMS) begin
            if (ph == 1 && !held && sent_words - start >= 40) begin
               hold_req = 1'b1;
               held     = 1'b1;
            end
            send_voxel(span);
         end
      end

      req_valid = 1'b0;
      while (density_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0 && density_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
